>>> rtl/core/tmb_pkg.sv
package tmb_pkg;

  // Matrix shape
  localparam int MATRIX_DIM = 4;
  localparam int ROW_W      = 2;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MATRIX_DIM - 1);

  // Angle datapath widths: reduced angle and CORDIC word
  localparam int ANG_W     = 35;
  localparam int CW        = 34;
  localparam int MAX_STEPS = 30;

  // Q2.30 angle constants
  localparam logic signed [25:0] DEG2RAD_Q30   = 26'sd18740330;
  localparam logic [32:0]        PI_Q30        = 33'd3373259426;
  localparam logic [32:0]        HALF_PI_Q30   = 33'd1686629713;
  localparam logic [32:0]        TWO_PI_Q30    = 33'd6746518852;
  localparam logic signed [CW-1:0] GAIN_INV_Q30 = 34'sd652032874;

  // CORDIC arctangent table, atan(2^-i) in Q2.30
  localparam logic [31:0] ATAN_Q30 [MAX_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  typedef logic signed [31:0] fix_t;

  typedef enum logic [2:0] {
    OP_ROT_X     = 3'd0,
    OP_ROT_Y     = 3'd1,
    OP_ROT_Z     = 3'd2,
    OP_ROT_AXIS  = 3'd3,
    OP_TRANSLATE = 3'd4,
    OP_SCALE     = 3'd5
  } tmb_op_e;

  typedef struct packed {
    logic [2:0] op;
    fix_t       angle;
    logic       unit_degrees;
    fix_t       vec_x;
    fix_t       vec_y;
    fix_t       vec_z;
  } tmb_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    fix_t             elem_c0;
    fix_t             elem_c1;
    fix_t             elem_c2;
    fix_t             elem_c3;
    logic             last_row;
  } tmb_out_t;

  // Fields that ride along with the angle pipeline
  typedef struct packed {
    logic [2:0] op;
    fix_t       vec_x;
    fix_t       vec_y;
    fix_t       vec_z;
  } tmb_side_t;

  // Clamp to 32-bit signed
  function automatic fix_t sat32(logic signed [65:0] v);
    fix_t res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Fixed-point product, rounded half up, saturated
  function automatic fix_t fx_mul(fix_t a, fix_t b, int frac);
    logic signed [63:0] p;
    p = a * b;
    p = (p + (64'sd1 <<< (frac - 1))) >>> frac;
    return sat32(66'(p));
  endfunction

endpackage

>>> rtl/core/tmb_angle.sv
module tmb_angle
  import tmb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  fix_t                  angle_i,
  input  logic                  deg_i,
  input  tmb_side_t             side_i,
  output logic                  valid_o,
  output logic signed [CW-1:0]  z_o,
  output logic                  flip_o,
  output tmb_side_t             side_o
);

  localparam int MAG_W  = 62 - FRAC_BITS;
  localparam int NRED   = 30 - FRAC_BITS;
  localparam int PROD_W = 58;

  // Stage 1: degree product and exact radian scaling
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MAG_W:0]    rad_q;
  logic                     deg_q;
  tmb_side_t                s1_side_q;
  logic                     s1_v_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= angle_i * DEG2RAD_Q30;
      rad_q     <= (MAG_W+1)'(angle_i) <<< (30 - FRAC_BITS);
      deg_q     <= deg_i;
      s1_side_q <= side_i;
    end
  end

  // Stage 2: round, select and take magnitude
  logic signed [PROD_W-1:0] rd;
  logic signed [MAG_W:0]    r;
  logic [MAG_W:0]           ra;

  assign rd = (prod_q + (58'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign r  = deg_q ? $signed(rd[MAG_W:0]) : rad_q;
  assign ra = r[MAG_W] ? $unsigned(-r) : $unsigned(r);

  logic [MAG_W-1:0] rm_q   [NRED+1];
  logic             neg_q  [NRED+1];
  tmb_side_t        rs_q   [NRED+1];
  logic             rv_q   [NRED+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rm_q[0]  <= ra[MAG_W-1:0];
      neg_q[0] <= r[MAG_W];
      rs_q[0]  <= s1_side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      rv_q[0] <= 1'b0;
    end else if (en_i) begin
      s1_v_q  <= valid_i;
      rv_q[0] <= s1_v_q;
    end
  end

  // Restoring reduction of the magnitude modulo 2pi, one shifted compare per stage
  for (genvar g = 0; g < NRED; g++) begin : g_red
    localparam logic [MAG_W-1:0] SUB = MAG_W'(TWO_PI_Q30) << (NRED - 1 - g);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rm_q[g+1]  <= (rm_q[g] >= SUB) ? rm_q[g] - SUB : rm_q[g];
        neg_q[g+1] <= neg_q[g];
        rs_q[g+1]  <= rs_q[g];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[g+1] <= 1'b0;
      end else if (en_i) begin
        rv_q[g+1] <= rv_q[g];
      end
    end
  end

  // Restore the sign and map into [-pi, pi)
  logic [32:0]             a;
  logic signed [ANG_W-1:0] ap;
  logic signed [ANG_W-1:0] tp;
  logic signed [ANG_W-1:0] rr_d;
  logic signed [ANG_W-1:0] rr_q;
  tmb_side_t               f1_side_q;
  logic                    f1_v_q;

  assign a  = rm_q[NRED][32:0];
  assign ap = $signed({2'b00, a});
  assign tp = $signed({2'b00, TWO_PI_Q30});

  always_comb begin
    if (!neg_q[NRED]) begin
      rr_d = (a < PI_Q30) ? ap : ap - tp;
    end else if (a == '0) begin
      rr_d = '0;
    end else if (a <= PI_Q30) begin
      rr_d = -ap;
    end else begin
      rr_d = tp - ap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q      <= rr_d;
      f1_side_q <= rs_q[NRED];
    end
  end

  // Fold into [-pi/2, pi/2] and flag the sign flip
  logic signed [ANG_W-1:0] pi_s;
  logic signed [ANG_W-1:0] hpi_s;
  logic signed [ANG_W-1:0] z_d;
  logic                    flip_d;

  assign pi_s  = $signed({2'b00, PI_Q30});
  assign hpi_s = $signed({2'b00, HALF_PI_Q30});

  always_comb begin
    if (rr_q > hpi_s) begin
      z_d    = rr_q - pi_s;
      flip_d = 1'b1;
    end else if (rr_q < -hpi_s) begin
      z_d    = rr_q + pi_s;
      flip_d = 1'b1;
    end else begin
      z_d    = rr_q;
      flip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_o    <= z_d[CW-1:0];
      flip_o <= flip_d;
      side_o <= f1_side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      f1_v_q  <= rv_q[NRED];
      valid_o <= f1_v_q;
    end
  end

endmodule

>>> rtl/core/tmb_cordic.sv
module tmb_cordic
  import tmb_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] z_i,
  input  logic                 flip_i,
  input  tmb_side_t            side_i,
  output logic                 valid_o,
  output fix_t                 cos_o,
  output fix_t                 sin_o,
  output tmb_side_t            side_o
);

  localparam logic signed [CW-1:0] RND = CW'(1) << (29 - FRAC_BITS);

  logic signed [CW-1:0] x_q    [1:CORDIC_STEPS];
  logic signed [CW-1:0] y_q    [1:CORDIC_STEPS];
  logic signed [CW-1:0] z_q    [1:CORDIC_STEPS];
  logic                 flip_q [1:CORDIC_STEPS];
  tmb_side_t            side_q [1:CORDIC_STEPS];
  logic                 v_q    [1:CORDIC_STEPS];

  // One micro-rotation per stage
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [CW-1:0] xa, ya, za, dx, dy, at;
    logic                 fa, va;
    tmb_side_t            sa;

    if (g == 0) begin : g_first
      assign xa = GAIN_INV_Q30;
      assign ya = '0;
      assign za = z_i;
      assign fa = flip_i;
      assign va = valid_i;
      assign sa = side_i;
    end else begin : g_next
      assign xa = x_q[g];
      assign ya = y_q[g];
      assign za = z_q[g];
      assign fa = flip_q[g];
      assign va = v_q[g];
      assign sa = side_q[g];
    end

    assign dx = ya >>> g;
    assign dy = xa >>> g;
    assign at = $signed(CW'(ATAN_Q30[g]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]    <= za[CW-1] ? xa + dx : xa - dx;
        y_q[g+1]    <= za[CW-1] ? ya - dy : ya + dy;
        z_q[g+1]    <= za[CW-1] ? za + at : za - at;
        flip_q[g+1] <= fa;
        side_q[g+1] <= sa;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= va;
      end
    end
  end

  // Round to the output format and undo the fold
  logic signed [CW-1:0] xr, yr, c_d, s_d;

  assign xr  = (x_q[CORDIC_STEPS] + RND) >>> (30 - FRAC_BITS);
  assign yr  = (y_q[CORDIC_STEPS] + RND) >>> (30 - FRAC_BITS);
  assign c_d = flip_q[CORDIC_STEPS] ? -xr : xr;
  assign s_d = flip_q[CORDIC_STEPS] ? -yr : yr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o  <= c_d[31:0];
      sin_o  <= s_d[31:0];
      side_o <= side_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v_q[CORDIC_STEPS];
    end
  end

endmodule

>>> rtl/core/tmb_lane.sv
module tmb_lane
  import tmb_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int ROW       = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  fix_t vec_i  [3],
  input  fix_t cos_i,
  input  fix_t sin_i,
  output fix_t elem_o [3]
);

  localparam fix_t ONE = fix_t'(32'd1 << FRAC_BITS);

  fix_t omc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      omc_q <= ONE - cos_i;
    end
  end

  // One element of the Rodrigues row per column slot
  for (genvar k = 0; k < 3; k++) begin : g_col
    localparam int  J     = 3 - ROW - k;
    localparam bit  MINUS = ((k + 3 - ROW) % 3) == 1;

    fix_t              q_q, u_q;
    logic signed [32:0] side_d, side_q, side2_q;

    if (k == ROW) begin : g_diag
      assign side_d = 33'(cos_i);
    end else begin : g_off
      fix_t t;
      assign t      = fx_mul(vec_i[J], sin_i, FRAC_BITS);
      assign side_d = MINUS ? -33'(t) : 33'(t);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q       <= fx_mul(vec_i[ROW], vec_i[k], FRAC_BITS);
        side_q    <= side_d;
        u_q       <= fx_mul(omc_q, q_q, FRAC_BITS);
        side2_q   <= side_q;
        elem_o[k] <= sat32(66'(u_q) + 66'(side2_q));
      end
    end
  end

endmodule

>>> rtl/core/tmb_merge.sv
module tmb_merge
  import tmb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  tmb_side_t side_i,
  input  fix_t      cos_i,
  input  fix_t      sin_i,
  input  fix_t      rod_i [3][3],
  output logic      take_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tmb_out_t  out_data_o
);

  localparam fix_t ONE = fix_t'(32'd1 << FRAC_BITS);

  fix_t             m     [MATRIX_DIM][MATRIX_DIM];
  fix_t             mat_q [MATRIX_DIM][MATRIX_DIM];
  logic [ROW_W-1:0] row_q;
  logic             ov_q;
  logic             load;

  // Assemble the matrix for the selected transform
  always_comb begin
    for (int r = 0; r < MATRIX_DIM; r++) begin
      for (int k = 0; k < MATRIX_DIM; k++) begin
        m[r][k] = (r == k) ? ONE : '0;
      end
    end
    case (tmb_op_e'(side_i.op))
      OP_ROT_X: begin
        m[1][1] = cos_i; m[1][2] = -sin_i;
        m[2][1] = sin_i; m[2][2] = cos_i;
      end
      OP_ROT_Y: begin
        m[0][0] = cos_i;  m[0][2] = sin_i;
        m[2][0] = -sin_i; m[2][2] = cos_i;
      end
      OP_ROT_Z: begin
        m[0][0] = cos_i; m[0][1] = -sin_i;
        m[1][0] = sin_i; m[1][1] = cos_i;
      end
      OP_ROT_AXIS: begin
        for (int r = 0; r < 3; r++) begin
          for (int k = 0; k < 3; k++) begin
            m[r][k] = rod_i[r][k];
          end
        end
      end
      OP_TRANSLATE: begin
        m[0][3] = side_i.vec_x;
        m[1][3] = side_i.vec_y;
        m[2][3] = side_i.vec_z;
      end
      OP_SCALE: begin
        m[0][0] = side_i.vec_x;
        m[1][1] = side_i.vec_y;
        m[2][2] = side_i.vec_z;
      end
      default: begin
      end
    endcase
  end

  // Take a new matrix when idle or once the last row of the current one leaves
  assign take_o = !ov_q || (!out_stall_i && (row_q == ROW_LAST));
  assign load   = valid_i && take_o;

  always_ff @(posedge clk_i) begin
    if (load) begin
      mat_q <= m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      row_q <= '0;
    end else if (load) begin
      ov_q  <= 1'b1;
      row_q <= '0;
    end else if (ov_q && !out_stall_i) begin
      if (row_q == ROW_LAST) begin
        ov_q <= 1'b0;
      end else begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  // Drive one row per beat
  assign out_valid_o          = ov_q;
  assign out_data_o.row_index = row_q;
  assign out_data_o.elem_c0   = mat_q[row_q][0];
  assign out_data_o.elem_c1   = mat_q[row_q][1];
  assign out_data_o.elem_c2   = mat_q[row_q][2];
  assign out_data_o.elem_c3   = mat_q[row_q][3];
  assign out_data_o.last_row  = (row_q == ROW_LAST);

endmodule

>>> rtl/core/transform_matrix_builder_unit.sv
// Path: angle scaling and magnitude, modulo-2pi reduction stages, range map and fold,
//   CORDIC stages, lane and delay registers, then the merge four-row output register.
// Output: four row beats per matrix; new requests enter while earlier ones are in flight,
//   and the pipeline holds while a finished matrix waits behind a full output register.
// Reset: asynchronous, active low; clears all valid bits and the row counter.
module transform_matrix_builder_unit
  import tmb_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tmb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tmb_out_t out_data_o
);

  localparam int DLY = 3;

  logic                 adv;
  logic                 take;

  tmb_side_t            in_side;
  logic                 an_v;
  logic signed [CW-1:0] an_z;
  logic                 an_flip;
  tmb_side_t            an_side;

  logic                 cs_v;
  fix_t                 cs_cos, cs_sin;
  tmb_side_t            cs_side;
  fix_t                 vec [3];
  fix_t                 rod [3][3];

  tmb_side_t            dly_side_q [DLY];
  fix_t                 dly_c_q    [DLY];
  fix_t                 dly_s_q    [DLY];
  logic                 dly_v_q    [DLY];

  // Advance the whole pipeline unless the final stage is blocked
  assign adv        = !dly_v_q[DLY-1] || take;
  assign in_stall_o = !adv;

  assign in_side.op    = in_data_i.op;
  assign in_side.vec_x = in_data_i.vec_x;
  assign in_side.vec_y = in_data_i.vec_y;
  assign in_side.vec_z = in_data_i.vec_z;

  tmb_angle #(
    .FRAC_BITS (FRAC_BITS)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .angle_i (in_data_i.angle),
    .deg_i   (in_data_i.unit_degrees),
    .side_i  (in_side),
    .valid_o (an_v),
    .z_o     (an_z),
    .flip_o  (an_flip),
    .side_o  (an_side)
  );

  tmb_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (an_v),
    .z_i     (an_z),
    .flip_i  (an_flip),
    .side_i  (an_side),
    .valid_o (cs_v),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin),
    .side_o  (cs_side)
  );

  assign vec[0] = cs_side.vec_x;
  assign vec[1] = cs_side.vec_y;
  assign vec[2] = cs_side.vec_z;

  // One lane per rotation row
  for (genvar g = 0; g < 3; g++) begin : g_lane
    tmb_lane #(
      .FRAC_BITS (FRAC_BITS),
      .ROW       (g)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .vec_i  (vec),
      .cos_i  (cs_cos),
      .sin_i  (cs_sin),
      .elem_o (rod[g])
    );
  end

  // Delay the item fields to line up with the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_side_q[0] <= cs_side;
      dly_c_q[0]    <= cs_cos;
      dly_s_q[0]    <= cs_sin;
      for (int i = 1; i < DLY; i++) begin
        dly_side_q[i] <= dly_side_q[i-1];
        dly_c_q[i]    <= dly_c_q[i-1];
        dly_s_q[i]    <= dly_s_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DLY; i++) begin
        dly_v_q[i] <= 1'b0;
      end
    end else if (adv) begin
      dly_v_q[0] <= cs_v;
      for (int i = 1; i < DLY; i++) begin
        dly_v_q[i] <= dly_v_q[i-1];
      end
    end
  end

  tmb_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dly_v_q[DLY-1]),
    .side_i      (dly_side_q[DLY-1]),
    .cos_i       (dly_c_q[DLY-1]),
    .sin_i       (dly_s_q[DLY-1]),
    .rod_i       (rod),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Rows of one matrix leave in order
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_row |=>
      out_valid_o && (out_data_o.row_index == $past(out_data_o.row_index) + 2'd1))
    else $error("row index did not advance after a non-final row beat");

  // A matrix opens with row zero
  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> out_data_o.row_index == '0)
    else $error("matrix did not start at row zero");

  // Last flag marks exactly the final row
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_row == (out_data_o.row_index == ROW_LAST)))
    else $error("last row flag disagrees with row index");

  // Input holds only while a finished matrix waits at the end of the pipeline
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> dly_v_q[DLY-1] && out_valid_o)
    else $error("input stalled with the pipeline end free");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import tmb_pkg::*;

  localparam int FRAC         = 16;
  localparam int STEPS        = 18;
  localparam int N_RANDOM     = 108;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;

  // Codes outside the op enum; both build the identity
  localparam logic [2:0] OP_IDENT_LO = 3'd6;
  localparam logic [2:0] OP_IDENT_HI = 3'd7;

  // Matrix predictor and store of expected row beats
  class matrix_scoreboard;
    tmb_out_t rows_q[$];
    int       errors;
    int       rows_seen;
    int       matrices;

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint round_down(longint v, int sh);
      if (sh == 0) return v;
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function longint qmul(longint a, longint b);
      return clamp32(round_down(a * b, FRAC));
    endfunction

    // Reduce the angle, fold it into the right half plane, run the CORDIC
    function void angle_trig(fix_t ang, logic deg, output longint c, output longint s);
      longint r, x, y, z, dx, dy, pi_v, two_pi_v, half_pi_v;
      bit     flip;
      pi_v      = longint'(PI_Q30);
      two_pi_v  = longint'(TWO_PI_Q30);
      half_pi_v = longint'(HALF_PI_Q30);
      flip      = 1'b0;
      if (deg) r = round_down(longint'(ang) * longint'(DEG2RAD_Q30), FRAC);
      else     r = longint'(ang) * (64'sd1 <<< (30 - FRAC));
      r = r % two_pi_v;
      if (r < 0) r += two_pi_v;
      if (r >= pi_v) r -= two_pi_v;
      if (r > half_pi_v) begin
        r -= pi_v;
        flip = 1'b1;
      end else if (r < -half_pi_v) begin
        r += pi_v;
        flip = 1'b1;
      end
      x = longint'(GAIN_INV_Q30);
      y = 0;
      z = r;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      x = round_down(x, 30 - FRAC);
      y = round_down(y, 30 - FRAC);
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // Note an accepted request: build its matrix and queue the four rows
    function void note_request(tmb_in_t req);
      longint m[4][4];
      longint one, c, s, vx, vy, vz, omc, xx, yy, zz, xy, yz, zx, xs, ys, zs;
      tmb_out_t row;
      one = 64'sd1 <<< FRAC;
      vx = longint'(req.vec_x); vy = longint'(req.vec_y); vz = longint'(req.vec_z);
      c = 0; s = 0;
      for (int r = 0; r < 4; r++)
        for (int k = 0; k < 4; k++) m[r][k] = (r == k) ? one : 0;
      if (req.op <= OP_ROT_AXIS) angle_trig(req.angle, req.unit_degrees, c, s);
      case (req.op)
        OP_ROT_X: begin
          m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
        end
        OP_ROT_Y: begin
          m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
        end
        OP_ROT_Z: begin
          m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
        end
        OP_ROT_AXIS: begin
          omc = one - c;
          xx = qmul(vx, vx); yy = qmul(vy, vy); zz = qmul(vz, vz);
          xy = qmul(vx, vy); yz = qmul(vy, vz); zx = qmul(vz, vx);
          xs = qmul(vx, s);  ys = qmul(vy, s);  zs = qmul(vz, s);
          m[0][0] = clamp32(qmul(omc, xx) + c);
          m[0][1] = clamp32(qmul(omc, xy) - zs);
          m[0][2] = clamp32(qmul(omc, zx) + ys);
          m[1][0] = clamp32(qmul(omc, xy) + zs);
          m[1][1] = clamp32(qmul(omc, yy) + c);
          m[1][2] = clamp32(qmul(omc, yz) - xs);
          m[2][0] = clamp32(qmul(omc, zx) - ys);
          m[2][1] = clamp32(qmul(omc, yz) + xs);
          m[2][2] = clamp32(qmul(omc, zz) + c);
        end
        OP_TRANSLATE: begin
          m[0][3] = vx; m[1][3] = vy; m[2][3] = vz;
        end
        OP_SCALE: begin
          m[0][0] = vx; m[1][1] = vy; m[2][2] = vz;
        end
        default: ;
      endcase
      for (int r = 0; r < 4; r++) begin
        row.row_index = ROW_W'(r);
        row.elem_c0   = fix_t'(clamp32(m[r][0]));
        row.elem_c1   = fix_t'(clamp32(m[r][1]));
        row.elem_c2   = fix_t'(clamp32(m[r][2]));
        row.elem_c3   = fix_t'(clamp32(m[r][3]));
        row.last_row  = (r == 3);
        rows_q.push_back(row);
      end
      matrices++;
    endfunction

    function void report(string field, longint e, longint a);
      errors++;
      $display("%0t: mismatch %s expected %0d actual %0d", $time, field, e, a);
    endfunction

    // Check one row beat against the oldest expected row
    function void check_row(tmb_out_t got);
      tmb_out_t want;
      rows_seen++;
      if (rows_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected row beat, expected none, actual %h", $time, got);
        return;
      end
      want = rows_q.pop_front();
      if (got.row_index !== want.row_index) report("row_index", want.row_index, got.row_index);
      if (got.elem_c0 !== want.elem_c0) report("elem_c0", want.elem_c0, got.elem_c0);
      if (got.elem_c1 !== want.elem_c1) report("elem_c1", want.elem_c1, got.elem_c1);
      if (got.elem_c2 !== want.elem_c2) report("elem_c2", want.elem_c2, got.elem_c2);
      if (got.elem_c3 !== want.elem_c3) report("elem_c3", want.elem_c3, got.elem_c3);
      if (got.last_row !== want.last_row) report("last_row", want.last_row, got.last_row);
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tmb_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tmb_out_t out_data_o;

  matrix_scoreboard sb;
  int  idle_cycles = 0;
  int  sent;

  transform_matrix_builder_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Observe accepted beats on both channels; watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_row(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d rows still expected", $time, sb.rows_q.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  // Offer one request beat after a random gap, hold until accepted
  task automatic send_request(tmb_in_t req);
    int gap;
    gap = ((sent % 40) < 10) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic send_fields(logic [2:0] op, fix_t ang, logic deg,
                             fix_t x, fix_t y, fix_t z);
    tmb_in_t req;
    req.op = op; req.angle = ang; req.unit_degrees = deg;
    req.vec_x = x; req.vec_y = y; req.vec_z = z;
    send_request(req);
  endtask

  function automatic fix_t rand_vec();
    fix_t v;
    v = $urandom;
    if ($urandom_range(0, 2) != 0) v = fix_t'($signed(v) >>> 14);
    return v;
  endfunction

  // Accept rows with random stalls, one long hold-off to back up the block
  initial begin : receiver
    int beats;
    int hold;
    beats = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (beats == 80) hold = HOLD_CYCLES;
      else if ((beats % 100) < 25) hold = 0;
      else hold = $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
    end
  end

  initial begin
    fix_t one;
    fix_t maxv;
    fix_t minv;
    one  = 32'sh0001_0000;
    maxv = 32'sh7fff_ffff;
    minv = 32'sh8000_0000;
    sb = new();
    sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every op, quadrant edges, extremes and saturation
    send_fields(OP_ROT_X, 0, 1'b1, 0, 0, 0);
    send_fields(OP_ROT_Y, 32'sd90 <<< 16, 1'b1, 0, 0, 0);
    send_fields(OP_ROT_Z, 32'sd180 <<< 16, 1'b1, 0, 0, 0);
    send_fields(OP_ROT_X, -(32'sd180 <<< 16), 1'b1, 0, 0, 0);
    send_fields(OP_ROT_Y, 32'sd270 <<< 16, 1'b1, 0, 0, 0);
    send_fields(OP_ROT_Z, 32'sd360 <<< 16, 1'b1, 0, 0, 0);
    send_fields(OP_ROT_Z, 32'sh0003_243f, 1'b0, 0, 0, 0);
    send_fields(OP_ROT_X, maxv, 1'b1, 0, 0, 0);
    send_fields(OP_ROT_Y, minv, 1'b1, 0, 0, 0);
    send_fields(OP_ROT_Z, maxv, 1'b0, 0, 0, 0);
    send_fields(OP_ROT_X, minv, 1'b0, 0, 0, 0);
    send_fields(OP_ROT_AXIS, 32'sd30 <<< 16, 1'b1, one, 0, 0);
    send_fields(OP_ROT_AXIS, 32'sd45 <<< 16, 1'b1, 0, 0, one);
    send_fields(OP_ROT_AXIS, 32'sd120 <<< 16, 1'b1, one, one, one);
    send_fields(OP_ROT_AXIS, 32'sd90 <<< 16, 1'b1, maxv, minv, maxv);
    send_fields(OP_ROT_AXIS, 32'sh0001_0000, 1'b0, minv, minv, minv);
    send_fields(OP_TRANSLATE, 0, 1'b0, maxv, minv, one);
    send_fields(OP_TRANSLATE, maxv, 1'b1, minv, 0, maxv);
    send_fields(OP_SCALE, 0, 1'b0, maxv, minv, 0);
    send_fields(OP_SCALE, 0, 1'b0, 32'sh0002_0000, -one, 32'sh0000_8000);
    send_fields(OP_IDENT_LO, maxv, 1'b1, maxv, maxv, maxv);
    send_fields(OP_IDENT_HI, minv, 1'b0, minv, minv, minv);

    // Random: mostly moderate angles and vectors, some full-range words
    repeat (N_RANDOM) begin
      tmb_in_t req;
      req.op = 3'($urandom_range(0, 7));
      req.unit_degrees = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) req.angle = $urandom;
      else if (req.unit_degrees) req.angle = fix_t'($signed($urandom) >>> 8);
      else req.angle = fix_t'($signed($urandom) >>> 12);
      req.vec_x = rand_vec();
      req.vec_y = rand_vec();
      req.vec_z = rand_vec();
      send_request(req);
    end
    in_valid_i <= 1'b0;

    // Drain every expected row, then let the pipeline settle
    while (sb.rows_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d matrix requests across all ops, %0d row beats checked.",
             sb.matrices, sb.rows_seen);
    $display("Random gaps and stalls on both sides, one long output hold-off.");
    if (sb.errors == 0 && sb.rows_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
